// ===== hdl/alu_rf_pkg.sv =====
// Shared types and constants for the 6502-style ALU and register file.
package alu_rf_pkg;

    localparam int unsigned FUNC_W     = 6;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned S_TDATA_W  = 16;
    localparam int unsigned M_TDATA_W  = 48;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_ADC     = 6'd0,
        FN_SBC     = 6'd1,
        FN_AND     = 6'd2,
        FN_ORA     = 6'd3,
        FN_EOR     = 6'd4,
        FN_BIT     = 6'd5,
        FN_CMP     = 6'd6,
        FN_CPX     = 6'd7,
        FN_CPY     = 6'd8,
        FN_ASL_M   = 6'd9,
        FN_LSR_M   = 6'd10,
        FN_ROL_M   = 6'd11,
        FN_ROR_M   = 6'd12,
        FN_ASL_A   = 6'd13,
        FN_LSR_A   = 6'd14,
        FN_ROL_A   = 6'd15,
        FN_ROR_A   = 6'd16,
        FN_INC     = 6'd17,
        FN_DEC     = 6'd18,
        FN_INX     = 6'd19,
        FN_DEX     = 6'd20,
        FN_INY     = 6'd21,
        FN_DEY     = 6'd22,
        FN_LDA     = 6'd23,
        FN_LDX     = 6'd24,
        FN_LDY     = 6'd25,
        FN_STA     = 6'd26,
        FN_STX     = 6'd27,
        FN_STY     = 6'd28,
        FN_TAX     = 6'd29,
        FN_TAY     = 6'd30,
        FN_TXA     = 6'd31,
        FN_TYA     = 6'd32,
        FN_TSX     = 6'd33,
        FN_TXS     = 6'd34,
        FN_CLC     = 6'd35,
        FN_SEC     = 6'd36,
        FN_CLI     = 6'd37,
        FN_SEI     = 6'd38,
        FN_CLV     = 6'd39,
        FN_CLD     = 6'd40,
        FN_SED     = 6'd41
    } t_func;

    // Status register bit positions
    localparam int unsigned FLG_C = 0;
    localparam int unsigned FLG_Z = 1;
    localparam int unsigned FLG_I = 2;
    localparam int unsigned FLG_D = 3;
    localparam int unsigned FLG_B = 4;
    localparam int unsigned FLG_U = 5;
    localparam int unsigned FLG_V = 6;
    localparam int unsigned FLG_N = 7;

    localparam logic [BYTE_W-1:0] SP_RESET = 8'hFF;

    // Master-side tdata field offsets
    localparam int unsigned OFS_RESULT = 0;
    localparam int unsigned OFS_WB     = 8;
    localparam int unsigned OFS_ACC    = 9;
    localparam int unsigned OFS_X      = 17;
    localparam int unsigned OFS_Y      = 25;
    localparam int unsigned OFS_FLAGS  = 33;

endpackage

// ===== hdl/cpu_alu_register_file_flags_top.sv =====
// Top level: binary-mode 6502 ALU with A, X, Y, S and P registers.
//
// Slave stream (i_s_*) carries one operation per transfer: a function code
// and an operand byte. Master stream (o_m_*) returns one result per
// operation: the write-back byte and flag, plus A, X, Y and P after it.
//
// Pipeline: a transfer accepted on i_s_* is captured in the input register,
// executed against the register file, which updates together with the
// output register, and is then offered on o_m_*.
// Throughput: one operation per cycle while the receiver takes results; a
// stall on i_m_tready holds it. The limit is the register file update: each
// operation reads A, X, Y, S, P as left by the one before.
//
// Reset (synchronous, active low) clears A, X, Y and P, sets S to 0xFF
// and empties both the input and output registers.
// When the receiver stalls, the output register holds its result; the
// input register still takes one more operation, after which o_s_tready
// drops until the output drains.
module cpu_alu_register_file_flags_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [5:0] func, [13:6] operand, [15:14] zero
    input  logic [alu_rf_pkg::S_TDATA_W-1:0] i_s_tdata,
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] result_byte, [8] write_back, [16:9] acc_out, [24:17] x_out,
    // [32:25] y_out, [40:33] flags_out, [47:41] zero
    output logic [alu_rf_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import alu_rf_pkg::*;

    // Input register
    logic              r_in_valid;
    logic [FUNC_W-1:0] r_func;
    logic [BYTE_W-1:0] r_operand;

    // Architectural registers
    logic [BYTE_W-1:0] r_acc, r_x, r_y, r_sp, r_flags;
    logic [BYTE_W-1:0] n_acc, n_x, n_y, n_sp, n_flags;

    // Output register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_res, r_out_acc, r_out_x, r_out_y, r_out_flags;
    logic              r_out_wb;
    logic [BYTE_W-1:0] n_res;
    logic              n_wb;

    logic out_free, exec, in_take;

    // Execute when an operation is waiting and the output can take it.
    assign out_free   = !r_out_valid || i_m_tready;
    assign exec       = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || exec;
    assign in_take    = i_s_tvalid && o_s_tready;

    // ALU datapath helpers
    logic [BYTE_W-1:0] add_m, cmp_reg, sh_src;
    logic [BYTE_W:0]   sum9, diff9;
    logic [BYTE_W-1:0] sh_res;
    logic              sh_c;
    logic [1:0]        sh_kind;

    always_comb begin
        add_m   = (r_func == FN_SBC) ? ~r_operand : r_operand;
        sum9    = {1'b0, r_acc} + {1'b0, add_m} + {{BYTE_W{1'b0}}, r_flags[FLG_C]};
        cmp_reg = (r_func == FN_CPX) ? r_x : ((r_func == FN_CPY) ? r_y : r_acc);
        diff9   = {1'b0, cmp_reg} - {1'b0, r_operand};
        // Memory shifts are codes 9..12, accumulator shifts 13..16.
        if (r_func <= FN_ROR_M) begin
            sh_src  = r_operand;
            sh_kind = 2'(r_func - FN_ASL_M);
        end else begin
            sh_src  = r_acc;
            sh_kind = 2'(r_func - FN_ASL_A);
        end
        case (sh_kind)
            2'd0: begin
                sh_c   = sh_src[BYTE_W-1];
                sh_res = {sh_src[BYTE_W-2:0], 1'b0};
            end
            2'd1: begin
                sh_c   = sh_src[0];
                sh_res = {1'b0, sh_src[BYTE_W-1:1]};
            end
            2'd2: begin
                sh_c   = sh_src[BYTE_W-1];
                sh_res = {sh_src[BYTE_W-2:0], r_flags[FLG_C]};
            end
            default: begin
                sh_c   = sh_src[0];
                sh_res = {r_flags[FLG_C], sh_src[BYTE_W-1:1]};
            end
        endcase
    end

    function automatic logic [BYTE_W-1:0] set_nz(input logic [BYTE_W-1:0] flags,
                                                 input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] f;
        f        = flags;
        f[FLG_Z] = (v == '0);
        f[FLG_N] = v[BYTE_W-1];
        return f;
    endfunction

    // Next register-file state for the operation in the input register
    always_comb begin
        n_acc   = r_acc;
        n_x     = r_x;
        n_y     = r_y;
        n_sp    = r_sp;
        n_flags = r_flags;
        n_res   = '0;
        n_wb    = 1'b0;
        unique case (r_func) inside
            FN_ADC, FN_SBC: begin
                n_acc          = sum9[BYTE_W-1:0];
                n_flags        = set_nz(r_flags, sum9[BYTE_W-1:0]);
                n_flags[FLG_C] = sum9[BYTE_W];
                n_flags[FLG_V] = (r_acc[7] ^ sum9[7]) & (add_m[7] ^ sum9[7]);
            end
            FN_AND: begin
                n_acc   = r_acc & r_operand;
                n_flags = set_nz(r_flags, r_acc & r_operand);
            end
            FN_ORA: begin
                n_acc   = r_acc | r_operand;
                n_flags = set_nz(r_flags, r_acc | r_operand);
            end
            FN_EOR: begin
                n_acc   = r_acc ^ r_operand;
                n_flags = set_nz(r_flags, r_acc ^ r_operand);
            end
            FN_BIT: begin
                n_flags[FLG_Z] = ((r_acc & r_operand) == '0);
                n_flags[FLG_V] = r_operand[6];
                n_flags[FLG_N] = r_operand[7];
            end
            FN_CMP, FN_CPX, FN_CPY: begin
                n_flags        = set_nz(r_flags, diff9[BYTE_W-1:0]);
                n_flags[FLG_C] = !diff9[BYTE_W];
            end
            FN_ASL_M, FN_LSR_M, FN_ROL_M, FN_ROR_M: begin
                n_res          = sh_res;
                n_wb           = 1'b1;
                n_flags        = set_nz(r_flags, sh_res);
                n_flags[FLG_C] = sh_c;
            end
            FN_ASL_A, FN_LSR_A, FN_ROL_A, FN_ROR_A: begin
                n_acc          = sh_res;
                n_flags        = set_nz(r_flags, sh_res);
                n_flags[FLG_C] = sh_c;
            end
            FN_INC: begin
                n_res   = r_operand + 8'd1;
                n_wb    = 1'b1;
                n_flags = set_nz(r_flags, r_operand + 8'd1);
            end
            FN_DEC: begin
                n_res   = r_operand - 8'd1;
                n_wb    = 1'b1;
                n_flags = set_nz(r_flags, r_operand - 8'd1);
            end
            FN_INX: begin
                n_x     = r_x + 8'd1;
                n_flags = set_nz(r_flags, r_x + 8'd1);
            end
            FN_DEX: begin
                n_x     = r_x - 8'd1;
                n_flags = set_nz(r_flags, r_x - 8'd1);
            end
            FN_INY: begin
                n_y     = r_y + 8'd1;
                n_flags = set_nz(r_flags, r_y + 8'd1);
            end
            FN_DEY: begin
                n_y     = r_y - 8'd1;
                n_flags = set_nz(r_flags, r_y - 8'd1);
            end
            FN_LDA: begin
                n_acc   = r_operand;
                n_flags = set_nz(r_flags, r_operand);
            end
            FN_LDX: begin
                n_x     = r_operand;
                n_flags = set_nz(r_flags, r_operand);
            end
            FN_LDY: begin
                n_y     = r_operand;
                n_flags = set_nz(r_flags, r_operand);
            end
            FN_STA: begin
                n_res = r_acc;
                n_wb  = 1'b1;
            end
            FN_STX: begin
                n_res = r_x;
                n_wb  = 1'b1;
            end
            FN_STY: begin
                n_res = r_y;
                n_wb  = 1'b1;
            end
            FN_TAX: begin
                n_x     = r_acc;
                n_flags = set_nz(r_flags, r_acc);
            end
            FN_TAY: begin
                n_y     = r_acc;
                n_flags = set_nz(r_flags, r_acc);
            end
            FN_TXA: begin
                n_acc   = r_x;
                n_flags = set_nz(r_flags, r_x);
            end
            FN_TYA: begin
                n_acc   = r_y;
                n_flags = set_nz(r_flags, r_y);
            end
            FN_TSX: begin
                n_x     = r_sp;
                n_flags = set_nz(r_flags, r_sp);
            end
            FN_TXS: n_sp = r_x;          // no flag change
            FN_CLC: n_flags[FLG_C] = 1'b0;
            FN_SEC: n_flags[FLG_C] = 1'b1;
            FN_CLI: n_flags[FLG_I] = 1'b0;
            FN_SEI: n_flags[FLG_I] = 1'b1;
            FN_CLV: n_flags[FLG_V] = 1'b0;
            FN_CLD: n_flags[FLG_D] = 1'b0;
            FN_SED: n_flags[FLG_D] = 1'b1;
            default: ;                   // unused codes: no change
        endcase
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (exec) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_func    <= i_s_tdata[FUNC_W-1:0];
            r_operand <= i_s_tdata[FUNC_W+BYTE_W-1:FUNC_W];
        end
    end

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_sp    <= SP_RESET;
            r_flags <= '0;
        end else if (exec) begin
            r_acc   <= n_acc;
            r_x     <= n_x;
            r_y     <= n_y;
            r_sp    <= n_sp;
            r_flags <= n_flags;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (exec) begin
            r_res       <= n_res;
            r_out_wb    <= n_wb;
            r_out_acc   <= n_acc;
            r_out_x     <= n_x;
            r_out_y     <= n_y;
            r_out_flags <= n_flags;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out_flags, r_out_y, r_out_x, r_out_acc, r_out_wb, r_res};

endmodule

// ===== hdl/cpu_alu_register_file_flags_chk.sv =====
// Port-level checker for the ALU top level, with its bind.
module cpu_alu_register_file_flags_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [alu_rf_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import alu_rf_pkg::*;

    // Output channel empties on reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output valid dropped while stalled");

    // A stalled result keeps its payload.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("output data changed while stalled");

    // Without write-back the result byte is zero.
    a_no_wb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[OFS_WB] |-> o_m_tdata[OFS_WB-1:OFS_RESULT] == '0)
        else $error("result byte nonzero without write-back");

    // B and the unused status bit never get set.
    a_fixed_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_m_tdata[OFS_FLAGS+FLG_B] && !o_m_tdata[OFS_FLAGS+FLG_U])
        else $error("B or bit 5 set in status");

endmodule

bind cpu_alu_register_file_flags_top cpu_alu_register_file_flags_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== tb/tb_cpu_alu_register_file_flags_top.sv =====
// Self-checking stream testbench for the 6502-style ALU and register file.
`timescale 1ns / 1ps

module tb_cpu_alu_register_file_flags_top;
    import alu_rf_pkg::*;

    // One expected result transfer, as the block should report it.
    typedef struct packed {
        logic [BYTE_W-1:0] result_byte;
        logic              write_back;
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] y;
        logic [BYTE_W-1:0] flags;
    } t_alu_outcome;

    // Mirrors A, X, Y, S, P and keeps the outcomes still owed by the block.
    class t_alu_outcome_board;
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] xr;
        logic [BYTE_W-1:0] yr;
        logic [BYTE_W-1:0] sp;
        logic [BYTE_W-1:0] pflags;
        t_alu_outcome      expected_outcomes[$];
        int                mismatches;
        int                checked;
        int                ops_seen;
        int                mem_writes;
        int                unused_codes;

        function new();
            acc = '0;
            xr = '0;
            yr = '0;
            sp = SP_RESET;
            pflags = '0;
            mismatches = 0;
            checked = 0;
            ops_seen = 0;
            mem_writes = 0;
            unused_codes = 0;
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction

        function void set_nz(logic [BYTE_W-1:0] v);
            pflags[FLG_Z] = (v == '0);
            pflags[FLG_N] = v[7];
        endfunction

        function void compare_with(logic [BYTE_W-1:0] r, logic [BYTE_W-1:0] m);
            pflags[FLG_C] = (r >= m);
            set_nz(r - m);
        endfunction

        // kind is the memory form of the shift; the accumulator forms map onto it
        function logic [BYTE_W-1:0] shift_op(t_func kind, logic [BYTE_W-1:0] v);
            logic              cin;
            logic [BYTE_W-1:0] r;
            cin = pflags[FLG_C];
            case (kind)
                FN_ASL_M: begin
                    pflags[FLG_C] = v[7];
                    r = {v[6:0], 1'b0};
                end
                FN_LSR_M: begin
                    pflags[FLG_C] = v[0];
                    r = {1'b0, v[7:1]};
                end
                FN_ROL_M: begin
                    pflags[FLG_C] = v[7];
                    r = {v[6:0], cin};
                end
                default: begin
                    pflags[FLG_C] = v[0];
                    r = {cin, v[7:1]};
                end
            endcase
            set_nz(r);
            return r;
        endfunction

        // Apply one accepted operation and queue the outcome it must produce.
        function void record_op(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] m);
            t_alu_outcome      want;
            logic [BYTE_W-1:0] addend;
            logic [BYTE_W:0]   sum;
            logic [BYTE_W-1:0] wbb;
            logic              wb;
            wbb = '0;
            wb = 1'b0;
            case (func)
                FN_ADC, FN_SBC: begin
                    addend = (func == FN_SBC) ? ~m : m;
                    sum = {1'b0, acc} + {1'b0, addend} + {{BYTE_W{1'b0}}, pflags[FLG_C]};
                    pflags[FLG_C] = sum[BYTE_W];
                    pflags[FLG_V] = (acc[7] ^ sum[7]) & (addend[7] ^ sum[7]);
                    acc = sum[BYTE_W-1:0];
                    set_nz(acc);
                end
                FN_AND: begin acc = acc & m; set_nz(acc); end
                FN_ORA: begin acc = acc | m; set_nz(acc); end
                FN_EOR: begin acc = acc ^ m; set_nz(acc); end
                FN_BIT: begin
                    pflags[FLG_Z] = ((acc & m) == '0);
                    pflags[FLG_V] = m[6];
                    pflags[FLG_N] = m[7];
                end
                FN_CMP: compare_with(acc, m);
                FN_CPX: compare_with(xr, m);
                FN_CPY: compare_with(yr, m);
                FN_ASL_M, FN_LSR_M, FN_ROL_M, FN_ROR_M: begin
                    wbb = shift_op(t_func'(func), m);
                    wb = 1'b1;
                end
                FN_ASL_A: acc = shift_op(FN_ASL_M, acc);
                FN_LSR_A: acc = shift_op(FN_LSR_M, acc);
                FN_ROL_A: acc = shift_op(FN_ROL_M, acc);
                FN_ROR_A: acc = shift_op(FN_ROR_M, acc);
                FN_INC: begin wbb = m + 8'd1; set_nz(wbb); wb = 1'b1; end
                FN_DEC: begin wbb = m - 8'd1; set_nz(wbb); wb = 1'b1; end
                FN_INX: begin xr = xr + 8'd1; set_nz(xr); end
                FN_DEX: begin xr = xr - 8'd1; set_nz(xr); end
                FN_INY: begin yr = yr + 8'd1; set_nz(yr); end
                FN_DEY: begin yr = yr - 8'd1; set_nz(yr); end
                FN_LDA: begin acc = m; set_nz(acc); end
                FN_LDX: begin xr = m; set_nz(xr); end
                FN_LDY: begin yr = m; set_nz(yr); end
                FN_STA: begin wbb = acc; wb = 1'b1; end
                FN_STX: begin wbb = xr; wb = 1'b1; end
                FN_STY: begin wbb = yr; wb = 1'b1; end
                FN_TAX: begin xr = acc; set_nz(xr); end
                FN_TAY: begin yr = acc; set_nz(yr); end
                FN_TXA: begin acc = xr; set_nz(acc); end
                FN_TYA: begin acc = yr; set_nz(acc); end
                FN_TSX: begin xr = sp; set_nz(xr); end
                FN_TXS: sp = xr;
                FN_CLC: pflags[FLG_C] = 1'b0;
                FN_SEC: pflags[FLG_C] = 1'b1;
                FN_CLI: pflags[FLG_I] = 1'b0;
                FN_SEI: pflags[FLG_I] = 1'b1;
                FN_CLV: pflags[FLG_V] = 1'b0;
                FN_CLD: pflags[FLG_D] = 1'b0;
                FN_SED: pflags[FLG_D] = 1'b1;
                default: unused_codes++;
            endcase
            ops_seen++;
            if (wb) mem_writes++;
            want.result_byte = wb ? wbb : '0;
            want.write_back = wb;
            want.acc = acc;
            want.x = xr;
            want.y = yr;
            want.flags = pflags;
            expected_outcomes = {expected_outcomes, want};
        endfunction

        function void cmp_field(string name, logic [BYTE_W-1:0] want,
                                logic [BYTE_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %h, actual %h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_outcome(logic [M_TDATA_W-1:0] bus);
            t_alu_outcome want;
            if (expected_outcomes.size() == 0) begin
                $error("result transfer with no operation outstanding: %h", bus);
                mismatches++;
                return;
            end
            want = expected_outcomes.pop_front();
            checked++;
            cmp_field("result_byte", want.result_byte, bus[OFS_RESULT +: BYTE_W]);
            cmp_field("write_back", {7'd0, want.write_back}, {7'd0, bus[OFS_WB]});
            cmp_field("acc_out", want.acc, bus[OFS_ACC +: BYTE_W]);
            cmp_field("x_out", want.x, bus[OFS_X +: BYTE_W]);
            cmp_field("y_out", want.y, bus[OFS_Y +: BYTE_W]);
            cmp_field("flags_out", want.flags, bus[OFS_FLAGS +: BYTE_W]);
        endfunction
    endclass

    localparam int RAND_OPS = 1150;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam logic [FUNC_W-1:0] FUNC_MAX = '1;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // [5:0] func, [13:6] operand, [15:14] zero
    logic [S_TDATA_W-1:0]   i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // [7:0] result_byte, [8] write_back, [16:9] acc_out, [24:17] x_out,
    // [32:25] y_out, [40:33] flags_out, [47:41] zero
    logic [M_TDATA_W-1:0]   o_m_tdata;

    // main sequence asks the receiver for one long hold-off
    bit                     hold_req = 1'b0;

    t_alu_outcome_board     board;

    cpu_alu_register_file_flags_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Offer one operation and hold it until the block takes it. Valid stays
    // high on return so back-to-back calls form a burst without a bubble.
    task automatic send_op(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] m);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, m, f};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        board.record_op(f, m);
    endtask

    // Drop valid for a gap; data wiggles meanwhile and must be ignored.
    task automatic pause_sender(input int cycles);
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= S_TDATA_W'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    // Let the pipe empty, one handshake at a time.
    task automatic drain_results();
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Mostly real operations, some unused codes mixed in.
    function automatic logic [FUNC_W-1:0] pick_func();
        if ($urandom_range(0, 9) == 0)
            return FUNC_W'($urandom_range(int'(FN_SED) + 1, int'(FUNC_MAX)));
        return FUNC_W'($urandom_range(int'(FN_ADC), int'(FN_SED)));
    endfunction

    // Boundary bytes often, since carry, overflow and zero live there.
    function automatic logic [BYTE_W-1:0] pick_operand();
        logic [BYTE_W-1:0] corners[8];
        corners = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF, 8'h40, 8'hC0};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 7)];
        return BYTE_W'($urandom);
    endfunction

    // Result monitor: every accepted master transfer goes to the board.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_outcome(o_m_tdata);
    end

    // Receiver: stretches of always-ready, coin-flip, mostly-ready and
    // mostly-stalled, plus one long hold-off when the sequence asks for it.
    initial begin : receiver
        int  mode;
        int  stretch;
        bit  hold_done;
        hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            mode = $urandom_range(0, 3);
            stretch = $urandom_range(1, 30);
            repeat (stretch) begin
                @(posedge i_clk);
                case (mode)
                    0: i_m_tready <= 1'b1;
                    1: i_m_tready <= 1'($urandom_range(0, 1));
                    2: i_m_tready <= ($urandom_range(0, 3) != 0);
                    default: i_m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
            if (hold_req && !hold_done) begin
                // output register and input register both fill, then the
                // block must drop o_s_tready while the sender keeps offering
                @(posedge i_clk);
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #500us;
        $display("DONE: errors detected");
        $finish;
    end

    // Main sequence: reset, directed checks, random bursts, drain, verdict.
    initial begin : main_seq
        int sent;
        int burst;
        board = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: overflow and carry edges of ADC/SBC from the reset state
        send_op(FN_TSX, 8'h00);     // X <- S reset value, N set
        send_op(FN_LDA, 8'h7F);
        send_op(FN_ADC, 8'h01);     // 0x7F + 1: signed overflow, N
        send_op(FN_ADC, 8'h80);     // 0x80 + 0x80: wraps to zero, C and V
        send_op(FN_SBC, 8'h00);     // carry in set, no borrow
        send_op(FN_SBC, 8'hFF);     // borrow, carry out cleared
        send_op(FN_CLV, 8'h00);
        send_op(FN_BIT, 8'hC0);     // N and V from operand, Z from A & m
        send_op(FN_CMP, 8'h01);     // equal compare
        send_op(FN_CPX, 8'hFF);
        send_op(FN_CPY, 8'h00);
        send_op(FN_SEC, 8'h00);
        send_op(FN_ROR_M, 8'h01);   // carry into bit 7, out of bit 0
        send_op(FN_ROL_A, 8'h00);
        send_op(FN_INC, 8'hFF);     // wrap to zero, written back
        send_op(FN_DEC, 8'h00);     // wrap to 0xFF
        send_op(FN_LDX, 8'h00);
        send_op(FN_TXS, 8'h80);     // stack pointer moves, flags untouched
        send_op(FN_TSX, 8'h00);
        send_op(FN_SED, 8'h00);     // decimal mode is stored only
        send_op(FN_ADC, 8'h19);     // still binary
        send_op(FN_SEI, 8'h00);
        send_op(FN_STA, 8'hA5);     // stored byte is A, not the operand
        send_op(FN_STY, 8'hFF);
        send_op(FUNC_MAX, 8'hFF);   // unused code: registers unchanged
        send_op(FN_SED + 6'd1, 8'h00);

        // Random: bursts of operations separated by random gaps
        sent = 0;
        while (sent < RAND_OPS) begin
            if (sent >= 300)
                hold_req = 1'b1;
            if (sent >= 700 && sent < 740) begin
                // one full drain mid-run
                pause_sender($urandom_range(1, 4));
                drain_results();
                sent = 740;
            end
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                send_op(pick_func(), pick_operand());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 8));
        end

        pause_sender(1);
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Checked %0d results of %0d ops (%0d write-backs, %0d unused codes)",
                 board.checked, board.ops_seen, board.mem_writes, board.unused_codes);
        $display("Traffic included bursts, gaps, receiver stalls, a long hold-off and a drain");
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
